>>> hdl/isingm_pkg.sv
`default_nettype none

package isingm_pkg;

    localparam int SIDE_DEFAULT = 128;

    localparam int COORD_W  = 7;
    localparam int PCT_W    = 7;
    localparam int ENERGY_W = 17;
    localparam int MAGNET_W = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_FOUR  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_EIGHT = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_CENTER,
        ST_READ_DOWN,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic                       accepted;
        logic                       new_spin;
        logic signed [ENERGY_W-1:0] total_energy;
        logic signed [MAGNET_W-1:0] magnet_sum;
    } eval_res_t;

endpackage

`default_nettype wire

>>> hdl/isingm_lattice.sv
`default_nettype none

module isingm_lattice #(
    parameter int SIDE = isingm_pkg::SIDE_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rd_a_en,
    input  wire logic [$clog2(SIDE)-1:0]  rd_a_addr,
    output logic      [SIDE-1:0]          rd_a_data,
    input  wire logic                     rd_b_en,
    input  wire logic [$clog2(SIDE)-1:0]  rd_b_addr,
    output logic      [SIDE-1:0]          rd_b_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SIDE)-1:0]  wr_addr,
    input  wire logic [SIDE-1:0]          wr_data
);

    logic [SIDE-1:0] mem [SIDE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/isingm_eval.sv
`default_nettype none

module isingm_eval #(
    parameter int SIDE = isingm_pkg::SIDE_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              center,
    input  wire logic                              nb_up,
    input  wire logic                              nb_down,
    input  wire logic                              nb_left,
    input  wire logic                              nb_right,
    input  wire logic [isingm_pkg::PCT_W-1:0]      random_pct,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0] limit_four,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0] limit_eight,
    output isingm_pkg::eval_res_t                  res
);

    import isingm_pkg::*;

    localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
    localparam logic [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SIDE * SIDE);

    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;
    logic signed [MAGNET_W-1:0] magnet_reg;
    logic signed [MAGNET_W-1:0] magnet_next;
    logic [2:0]                 same_cnt;
    logic signed [ENERGY_W-1:0] delta_e;
    logic                       acc;

    // Each neighbor aligned with the center adds 4 to the energy change.
    assign same_cnt = 3'(nb_up    == center) + 3'(nb_down  == center)
                    + 3'(nb_left  == center) + 3'(nb_right == center);

    always_comb
    begin
        case (same_cnt)
            3'd0:    delta_e = -ENERGY_W'(sreg8());
            3'd1:    delta_e = -ENERGY_W'(4);
            3'd2:    delta_e = '0;
            3'd3:    delta_e = ENERGY_W'(4);
            default: delta_e = ENERGY_W'(8);
        endcase
        case (same_cnt)
            3'd3:    acc = (random_pct <= limit_four);
            3'd4:    acc = (random_pct <= limit_eight);
            default: acc = 1'b1;
        endcase
        energy_next = energy_reg;
        magnet_next = magnet_reg;
        if (acc)
        begin
            energy_next = energy_reg + delta_e;
            magnet_next = center ? magnet_reg - MAGNET_W'(2) : magnet_reg + MAGNET_W'(2);
        end
    end

    function automatic int sreg8();
        return 8;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= ENERGY_RESET;
            magnet_reg <= MAGNET_RESET;
        end
        else if (en)
        begin
            energy_reg <= energy_next;
            magnet_reg <= magnet_next;
        end
    end

    assign res.accepted     = acc;
    assign res.new_spin     = center ^ acc;
    assign res.total_energy = energy_next;
    assign res.magnet_sum   = magnet_next;

endmodule

`default_nettype wire

>>> hdl/ising_metropolis_spin_flip.sv
// Metropolis single-spin update on a wrapped SIDE x SIDE lattice of one-bit spins.
// Input beats on s_* name a site and carry a random percent; each one yields
// exactly one output beat on m_* with the acceptance, the spin afterwards and
// the running energy and magnetization of the whole lattice.
// The lattice is a row-wide memory with two read ports. An attempt reads the row
// above and the center row, then the row below, and writes the center row back
// as its result enters the output register. A new input beat is taken only
// after the current attempt has written its row back.
// The output register decouples the channels: a new input beat is taken while a
// result still waits, and the update stalls only when a second result is ready
// before the first one is taken. m_tdata holds steady while m_tready is low.
// After reset the block sweeps the memory one row a cycle to set every spin up;
// s_tready stays low until the sweep is done. Reset also sets the energy to
// minus two times the site count, the magnetization to the site count and both
// acceptance limits to zero. cfg_we writes a limit in the same cycle. The user
// changes limits only while no attempt is in flight; the block does not enforce it.
`default_nettype none

module ising_metropolis_spin_flip #(
    parameter int SIDE = isingm_pkg::SIDE_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // site_row[6:0], site_col[13:7], random_pct[20:14], zero fill above
    input  wire logic [isingm_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // accepted[0], new_spin[1], total_energy[18:2], magnet_sum[34:19], zero fill above
    output logic      [isingm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [isingm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import isingm_pkg::*;

    localparam int AW = $clog2(SIDE);
    localparam logic [AW-1:0] LAST = AW'(SIDE - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]         row_reg, row_next;
    logic [AW-1:0]         col_reg, col_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;
    logic                  up_bit_reg, up_bit_next;
    logic [CFG_DATA_W-1:0] limit_four_reg;
    logic [CFG_DATA_W-1:0] limit_eight_reg;
    logic                  m_valid_reg, m_valid_next;
    eval_res_t             out_res_reg;

    logic [AW-1:0]   row_up, row_down, col_left, col_right;
    logic            rd_a_en, rd_b_en, wr_en;
    logic [AW-1:0]   rd_a_addr, rd_b_addr, wr_addr;
    logic [SIDE-1:0] rd_a_data, rd_b_data, wr_data, row_flip;
    logic            eval_en;
    eval_res_t       eval_res;

    function automatic logic [AW-1:0] wrap_coord(input logic [COORD_W-1:0] v);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << COORD_W); i++)
        begin
            if (v == COORD_W'(i))
            begin
                r = AW'(i % SIDE);
            end
        end
        return r;
    endfunction

    assign row_up    = (row_reg == '0)  ? LAST : row_reg - AW'(1);
    assign row_down  = (row_reg == LAST) ? '0  : row_reg + AW'(1);
    assign col_left  = (col_reg == '0)  ? LAST : col_reg - AW'(1);
    assign col_right = (col_reg == LAST) ? '0  : col_reg + AW'(1);

    always_comb
    begin
        row_flip          = rd_b_data;
        row_flip[col_reg] = eval_res.new_spin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        pct_reg    <= pct_next;
        up_bit_reg <= up_bit_next;
        if (eval_en)
        begin
            out_res_reg <= eval_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_four_reg  <= '0;
            limit_eight_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEPT_FOUR:  limit_four_reg  <= cfg_data;
                CFG_ACCEPT_EIGHT: limit_eight_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        pct_next     = pct_reg;
        up_bit_next  = up_bit_reg;
        s_tready     = 1'b0;
        rd_a_en      = 1'b0;
        rd_a_addr    = row_up;
        rd_b_en      = 1'b0;
        rd_b_addr    = row_reg;
        wr_en        = 1'b0;
        wr_addr      = row_reg;
        wr_data      = row_flip;
        eval_en      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    row_next   = wrap_coord(s_tdata[COORD_W-1:0]);
                    col_next   = wrap_coord(s_tdata[2*COORD_W-1:COORD_W]);
                    pct_next   = s_tdata[2*COORD_W+PCT_W-1:2*COORD_W];
                    state_next = ST_READ_CENTER;
                end
            end
            ST_READ_CENTER:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = row_up;
                rd_b_en    = 1'b1;
                rd_b_addr  = row_reg;
                state_next = ST_READ_DOWN;
            end
            ST_READ_DOWN:
            begin
                up_bit_next = rd_a_data[col_reg];
                rd_a_en     = 1'b1;
                rd_a_addr   = row_down;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    eval_en    = 1'b1;
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (eval_en)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    isingm_lattice #(
        .SIDE(SIDE)
    ) u_lattice (
        .clk       (clk),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    isingm_eval #(
        .SIDE(SIDE)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (eval_en),
        .center      (rd_b_data[col_reg]),
        .nb_up       (up_bit_reg),
        .nb_down     (rd_a_data[col_reg]),
        .nb_left     (rd_b_data[col_left]),
        .nb_right    (rd_b_data[col_right]),
        .random_pct  (pct_reg),
        .limit_four  (limit_four_reg),
        .limit_eight (limit_eight_reg),
        .res         (eval_res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {
        (OUT_DATA_W - 2 - ENERGY_W - MAGNET_W)'(0),
        out_res_reg.magnet_sum,
        out_res_reg.total_energy,
        out_res_reg.new_spin,
        out_res_reg.accepted
    };

`ifndef SYNTHESIS
    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("input taken while an attempt is in flight");

    property p_result_after_update;
        @(posedge clk) disable iff (!rst_n)
        eval_en |=> m_tvalid && !$stable(state_reg);
    endproperty
    a_result_after_update: assert property (p_result_after_update)
        else $error("update did not present a result");

    property p_quiet_during_clear;
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid;
    endproperty
    a_quiet_during_clear: assert property (p_quiet_during_clear)
        else $error("channel active during lattice clear");
`endif

endmodule

`default_nettype wire
